### src/pbce_pkg.sv
// ----------------------------------------------------------------------------
// pbce_pkg
// Shared types and constants of the pixel binarize change encoder: beat
// formats, the command that travels from the front end to the back end,
// cell map codes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package pbce_pkg;

  // Cell map geometry
  localparam int unsigned CELLS        = 8192;
  localparam int unsigned IDX_W        = $clog2(CELLS);
  localparam int unsigned CELL_INDEX_W = 13;

  // Queue depths
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned OQ_DEPTH  = 2;
  localparam int unsigned OQ_PTR_W  = $clog2(OQ_DEPTH);

  // Conversion coefficients, Q8, truncated toward zero
  localparam logic signed [9:0] COEF_RV = 10'sd358;  // 1.402
  localparam logic signed [9:0] COEF_GU = 10'sd88;   // 0.344
  localparam logic signed [9:0] COEF_GV = 10'sd182;  // 0.714
  localparam logic signed [9:0] COEF_BU = 10'sd453;  // 1.772

  // Configuration register reset values
  localparam logic [7:0] LIT_THRESHOLD_RST = 8'd70;
  localparam logic [8:0] LINE_STRIDE_RST   = 9'd80;
  localparam logic [8:0] FRAME_HEIGHT_RST  = 9'd60;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_LIT_THRESHOLD = 2'd0,
    CFG_LINE_STRIDE   = 2'd1,
    CFG_FRAME_HEIGHT  = 2'd2
  } cfg_reg_e;

  // Stored cell states
  typedef enum logic [1:0] {
    CELL_UNKNOWN = 2'd0,
    CELL_DARK    = 2'd1,
    CELL_LIT     = 2'd2
  } cell_e;

  // Result kinds
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_DRAW   = 1'b1;

  // Input beat
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic [7:0] col;
    logic [7:0] row;
    logic       frame_end;
  } pix_t;

  // Result beat
  typedef struct packed {
    logic                    kind;
    logic [CELL_INDEX_W-1:0] cell_index;
    logic                    lit;
    logic                    last;
  } res_t;

  // Classified pixel handed from front end to back end
  typedef struct packed {
    logic             upd;   // cell lookup wanted
    logic [IDX_W-1:0] idx;
    logic             lit;
    logic             fend;  // draw marker wanted
  } cmd_t;

endpackage

`default_nettype wire

### src/pbce_front.sv
// ----------------------------------------------------------------------------
// pbce_front
// Front end: holds the configuration registers, takes pixel beats, forms
// the color products and the row offset in one register stage, then
// classifies the pixel (lit, row kept, index in range) into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module pbce_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            take_i,
  input  wire pbce_pkg::pix_t  pix_i,
  output logic                 ready_o,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [8:0]      cfg_data_i,
  output logic                 cmd_push_o,
  output pbce_pkg::cmd_t       cmd_o,
  input  wire logic            cmd_full_i
);
  import pbce_pkg::*;

  logic [7:0] thr_q;
  logic [8:0] stride_q;
  logic [8:0] height_q;

  logic               s1_valid_q;
  logic [7:0]         luma_q;
  logic signed [17:0] rv_q, rv_d;
  logic signed [17:0] gc_q, gc_d;
  logic signed [17:0] bu_q, bu_d;
  logic [17:0]        prod_q, prod_d;
  logic [7:0]         col_q;
  logic               row_ok_q, row_ok_d;
  logic               fend_q;

  logic signed [7:0]  u, v;
  logic signed [18:0] base, r8, g8, b8, lim;
  logic [18:0]        idx_full;
  logic               in_range, pix_lit, need_cmd, s1_take;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= LIT_THRESHOLD_RST;
      stride_q <= LINE_STRIDE_RST;
      height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_LIT_THRESHOLD: thr_q    <= cfg_data_i[7:0];
        CFG_LINE_STRIDE:   stride_q <= cfg_data_i;
        CFG_FRAME_HEIGHT:  height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Products of the incoming beat
  always_comb begin
    u      = $signed(pix_i.chroma_blue ^ 8'h80);
    v      = $signed(pix_i.chroma_red ^ 8'h80);
    rv_d   = 18'(v) * 18'(COEF_RV);
    gc_d   = -(18'(u) * 18'(COEF_GU)) - (18'(v) * 18'(COEF_GV));
    bu_d   = 18'(u) * 18'(COEF_BU);
    prod_d = {9'd0, ({1'b0, pix_i.row} + 9'd1)} * {9'd0, stride_q};
    row_ok_d = ({2'b00, pix_i.row} + 10'd2) < {1'b0, height_q};
  end

  // Stage 1 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (take_i) begin
      s1_valid_q <= 1'b1;
    end else if (s1_take) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      luma_q   <= pix_i.luma;
      rv_q     <= rv_d;
      gc_q     <= gc_d;
      bu_q     <= bu_d;
      prod_q   <= prod_d;
      col_q    <= pix_i.col;
      row_ok_q <= row_ok_d;
      fend_q   <= pix_i.frame_end;
    end
  end

  // Classification: channel at least (threshold+1)*256, index check
  always_comb begin
    base     = $signed({3'b000, luma_q, 8'h00});
    r8       = base + 19'(rv_q);
    g8       = base + 19'(gc_q);
    b8       = base + 19'(bu_q);
    lim      = $signed({2'b00, {1'b0, thr_q} + 9'd1, 8'h00});
    pix_lit  = (r8 >= lim) || (g8 >= lim) || (b8 >= lim);
    idx_full = {1'b0, prod_q} + {11'd0, col_q};
    in_range = idx_full < 19'(CELLS);

    cmd_o.upd  = row_ok_q && in_range;
    cmd_o.idx  = idx_full[IDX_W-1:0];
    cmd_o.lit  = pix_lit;
    cmd_o.fend = fend_q;

    // Pixels that can give no result are dropped here
    need_cmd   = cmd_o.upd || fend_q;
    cmd_push_o = s1_valid_q && need_cmd && !cmd_full_i;
    s1_take    = s1_valid_q && (!need_cmd || !cmd_full_i);
    ready_o    = !s1_valid_q || s1_take;
  end

endmodule

`default_nettype wire

### src/pbce_cmd_fifo.sv
// ----------------------------------------------------------------------------
// pbce_cmd_fifo
// Command queue between front end and back end; lets either side stall
// without holding the other.
// ----------------------------------------------------------------------------
`default_nettype none

module pbce_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire pbce_pkg::cmd_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output pbce_pkg::cmd_t      data_o,
  output logic                empty_o
);
  import pbce_pkg::*;

  cmd_t                 slot_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wptr_q, rptr_q;
  logic [CMD_PTR_W:0]   cnt_q;

  assign full_o  = cnt_q == (CMD_PTR_W + 1)'(CMD_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = slot_q[rptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= data_i;
  end

endmodule

`default_nettype wire

### src/pbce_back.sv
// ----------------------------------------------------------------------------
// pbce_back
// Back end: owns the cell map memory. Clears it after reset, looks up each
// command's cell, writes changed cells, and queues update and draw marker
// beats in a two-entry result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module pbce_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire pbce_pkg::cmd_t cmd_i,
  input  wire logic           cmd_empty_i,
  output logic                cmd_pop_o,
  output logic                clearing_o,
  output pbce_pkg::res_t      res_o,
  output logic                empty_o,
  input  wire logic           pop_i
);
  import pbce_pkg::*;

  // Cell map
  cell_e            mem [CELLS];
  cell_e            rdata_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  cell_e            mem_wdata;

  // Clearing sweep
  logic             clr_q;
  logic [IDX_W-1:0] clr_addr_q;

  // Lookup stage
  logic  b_valid_q, b_phase_q, fwd_q;
  cmd_t  b_cmd_q;
  cell_e fwd_val_q, old_val, want;
  logic  need_upd, need_mark, push_res, step, b_done, upd_we, advance;
  res_t  res_d;

  // Result buffer
  res_t                oq_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] owp_q, orp_q;
  logic [OQ_PTR_W:0]   ocnt_q;
  logic                o_room, o_pop;

  assign clearing_o = clr_q;

  // Clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == IDX_W'(CELLS - 1)) clr_q <= 1'b0;
    end
  end

  // Result selection for the item in the lookup stage
  always_comb begin
    old_val   = fwd_q ? fwd_val_q : rdata_q;
    want      = b_cmd_q.lit ? CELL_LIT : CELL_DARK;
    need_upd  = b_cmd_q.upd && !b_phase_q && (old_val != want);
    need_mark = b_cmd_q.fend;
    push_res  = b_valid_q && (need_upd || need_mark);
    o_room    = ocnt_q < (OQ_PTR_W + 1)'(OQ_DEPTH);
    step      = b_valid_q && (!(need_upd || need_mark) || o_room);
    b_done    = step && !(need_upd && need_mark);
    upd_we    = step && need_upd;
    advance   = !cmd_empty_i && !clr_q && (!b_valid_q || b_done);
    cmd_pop_o = advance;

    if (need_upd) begin
      res_d.kind       = KIND_UPDATE;
      res_d.cell_index = CELL_INDEX_W'(b_cmd_q.idx);
      res_d.lit        = b_cmd_q.lit;
      res_d.last       = !b_cmd_q.fend;
    end else begin
      res_d.kind       = KIND_DRAW;
      res_d.cell_index = '0;
      res_d.lit        = 1'b0;
      res_d.last       = 1'b1;
    end
  end

  // Memory write port: sweep or cell update
  always_comb begin
    mem_we    = clr_q || upd_we;
    mem_waddr = clr_q ? clr_addr_q : b_cmd_q.idx;
    mem_wdata = clr_q ? CELL_UNKNOWN : want;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (advance) rdata_q <= mem[cmd_i.idx];
  end

  // Lookup stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_phase_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else if (advance) begin
      b_valid_q <= 1'b1;
      b_phase_q <= 1'b0;
      // same-cycle write to the cell being read
      fwd_q     <= upd_we && (b_cmd_q.idx == cmd_i.idx);
    end else if (b_done) begin
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else if (upd_we) begin
      b_phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b_cmd_q   <= cmd_i;
      fwd_val_q <= want;
    end
  end

  // Result buffer
  assign empty_o = ocnt_q == '0;
  assign res_o   = oq_q[orp_q];
  assign o_pop   = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (step && push_res) owp_q <= owp_q + 1'b1;
      if (o_pop)            orp_q <= orp_q + 1'b1;
      case ({step && push_res, o_pop})
        2'b10:   ocnt_q <= ocnt_q + 1'b1;
        2'b01:   ocnt_q <= ocnt_q - 1'b1;
        default: ocnt_q <= ocnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && push_res) oq_q[owp_q] <= res_d;
  end

`ifndef NO_ASSERTIONS
  // No command is taken while the map is being cleared
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !cmd_pop_o)
    else $error("command popped during clearing sweep");

  // Result buffer never overfills
  a_oq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= (OQ_PTR_W + 1)'(OQ_DEPTH))
    else $error("result buffer overflow");

  // An update followed by a marker keeps the item for a second beat
  a_mark_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_we && need_mark) |=> (b_valid_q && b_phase_q))
    else $error("draw marker beat lost after update");

  // Forwarded data only belongs to a live item
  a_fwd_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> b_valid_q)
    else $error("forward flag without item");

  // Cell updates never collide with the clearing sweep
  a_upd_not_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !b_valid_q)
    else $error("lookup active during clearing sweep");
`endif

endmodule

`default_nettype wire

### src/pixel_binarize_change_encoder_unit.sv
// ----------------------------------------------------------------------------
// pixel_binarize_change_encoder_unit
// Binarizes a YUV pixel stream against a threshold and reports cells of a
// stored map whose lit/dark state changes, plus draw markers at frame end.
//
//   channel   direction  handshake          payload
//   pixel     in         push / full        pixel_i  (pix_t)
//   result    out        pop / empty        result_o (res_t)
//   config    in         cfg_we_i           cfg_idx_i, cfg_data_i
//
// One pixel per clock sustained while the result side does not stall; a pixel
// that gives both an update and a draw marker holds the cell lookup stage for
// a second beat, since the result buffer takes one beat per cycle.
// When nothing stalls, a pixel passes the stage 1 registers, the command queue
// and the cell lookup stage into the result buffer, which drives the ports.
// After reset the cell map is cleared one entry per cycle: full stays high
// until all CELLS entries are cleared; configuration writes are taken meanwhile.
// A stall on the result side backs up through the command queue to full.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_binarize_change_encoder_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire pbce_pkg::pix_t pixel_i,
  output logic                empty,
  input  wire logic           pop,
  output pbce_pkg::res_t      result_o,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_idx_i,
  input  wire logic [8:0]     cfg_data_i
);
  import pbce_pkg::*;

  logic front_ready, clearing, take;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;

  // Input beat acceptance
  assign full = !front_ready || clearing;
  assign take = push && !full;

  pbce_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .pix_i      (pixel_i),
    .ready_o    (front_ready),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  pbce_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  pbce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .clearing_o  (clearing),
    .res_o       (result_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

`default_nettype wire
